FILE: sv/running_mean_stddev_unit_assert.svh
// Assertion macros shared by the running mean and standard deviation unit.
`ifndef RUNNING_MEAN_STDDEV_UNIT_ASSERT_SVH
`define RUNNING_MEAN_STDDEV_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RMSD_CHECK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define RMSD_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RMSD_CHECK(label, prop, msg)
`define RMSD_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: sv/rmsd_pkg.sv
// Shared widths, step counts and controller/datapath interface types.
package rmsd_pkg;

	localparam int COUNT_W       = 32;
	localparam int MEAN_OUT_W    = 40;
	localparam int SD_W          = 32;
	localparam int M2_W          = 64;
	localparam int WIDE_W        = 64;
	localparam int DVD_W         = 64;
	localparam int DSR_W         = 32;
	localparam int SD_ALIGN_FRAC = 16;
	localparam int ITER_W        = 6;
	localparam int DIV_STEPS     = 64;
	localparam int SQRT_STEPS    = 32;

	typedef struct packed {
		logic load;
		logic delta;
		logic div_mag;
		logic div_var;
		logic div_step;
		logic round;
		logic mean_upd;
		logic mul_step;
		logic m2_round;
		logic m2_acc;
		logic sd_zero;
		logic sqrt_load;
		logic sqrt_step;
		logic sd_take;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic few;
		logic out_free;
	} stat_t;

endpackage

FILE: sv/rmsd_div.sv
// Restoring divider, one quotient bit per step.
module rmsd_div (
	input  logic                        clk,
	input  logic                        load,
	input  logic                        step,
	input  logic [rmsd_pkg::DVD_W-1:0] dividend,
	input  logic [rmsd_pkg::DSR_W-1:0] divisor,
	output logic [rmsd_pkg::DVD_W-1:0] quotient,
	output logic [rmsd_pkg::DSR_W-1:0] remainder
);
	import rmsd_pkg::*;

	logic [DVD_W-1:0] dvd_q;
	logic [DSR_W-1:0] rem_q;
	logic [DSR_W-1:0] dsr_q;
	logic [DSR_W:0]   trial;
	logic [DSR_W:0]   diff;
	logic             fits;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	// quotient bits shift in at the bottom as dividend bits leave the top
	always_ff @(posedge clk) begin
		if (load) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (step) begin
			rem_q <= fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
		end
	end

	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

FILE: sv/rmsd_sqrt.sv
// Digit-by-digit integer square root, one root bit per step.
module rmsd_sqrt (
	input  logic                       clk,
	input  logic                       load,
	input  logic                       step,
	input  logic [rmsd_pkg::M2_W-1:0] value,
	output logic [rmsd_pkg::SD_W-1:0] root
);
	import rmsd_pkg::*;

	logic [M2_W-1:0] val_q;
	logic [SD_W+1:0] rem_q;
	logic [SD_W-1:0] root_q;
	logic [SD_W+3:0] pull;
	logic [SD_W+3:0] trial;
	logic [SD_W+3:0] diff;
	logic            fits;

	assign pull  = {rem_q, val_q[M2_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign diff  = pull - trial;
	assign fits  = pull >= trial;

	always_ff @(posedge clk) begin
		if (load) begin
			val_q  <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (step) begin
			rem_q  <= fits ? diff[SD_W+1:0] : pull[SD_W+1:0];
			root_q <= {root_q[SD_W-2:0], fits};
			val_q  <= {val_q[M2_W-3:0], 2'b00};
		end
	end

	assign root = root_q;

endmodule

FILE: sv/rmsd_dp.sv
// Datapath: Welford state, serial multiplier, shared divider, square root, output register.
`include "running_mean_stddev_unit_assert.svh"
module rmsd_dp #(
	parameter int SAMPLE_BITS    = 24,
	parameter int MEAN_FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  rmsd_pkg::cmd_t                        cmd,
	output rmsd_pkg::stat_t                       st,
	input  logic signed [SAMPLE_BITS-1:0]         sample_mm,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [rmsd_pkg::COUNT_W-1:0]          sample_count,
	output logic signed [rmsd_pkg::MEAN_OUT_W-1:0] mean_q16,
	output logic [rmsd_pkg::SD_W-1:0]             stddev_q8,
	output logic                                  saturated
);
	import rmsd_pkg::*;

	localparam int QW    = SAMPLE_BITS + MEAN_FRAC_BITS;
	localparam int MAG_W = QW + 1;
	localparam int PW    = 2 * MAG_W;
	localparam int EW    = (PW + 1 > M2_W + 1) ? PW + 1 : M2_W + 1;
	localparam logic [PW:0] HALF = (PW + 1)'(1) << (MEAN_FRAC_BITS - 1);

	logic [COUNT_W-1:0]       count_q;
	logic signed [QW-1:0]     mean_q;
	logic [M2_W-1:0]          m2_q;
	logic signed [QW-1:0]     xq_q;
	logic signed [MAG_W-1:0]  delta_q;
	logic                     neg_q;
	logic [MAG_W-1:0]         dm_q;
	logic [MAG_W-1:0]         q_q;
	logic [PW-1:0]            prod_q;
	logic [M2_W-1:0]          add_q;
	logic                     sat_q;
	logic [SD_W-1:0]          sd_q;
	logic                     out_valid_q;
	logic [COUNT_W-1:0]       cnt_out_q;
	logic [MEAN_OUT_W-1:0]    mean_out_q;
	logic [SD_W-1:0]          sd_out_q;
	logic                     sat_out_q;

	logic [MAG_W-1:0]         dm_abs;
	logic [DVD_W-1:0]         div_dvd;
	logic [DSR_W-1:0]         div_dsr;
	logic [DVD_W-1:0]         div_quo;
	logic [DSR_W-1:0]         div_rem;
	logic                     rnd_up;
	logic [MAG_W-1:0]         q_next;
	logic [MAG_W:0]           mul_sum;
	logic [PW:0]              rounded;
	logic [EW-1:0]            scaled;
	logic                     ovf;
	logic [M2_W:0]            acc_sum;
	logic [M2_W-1:0]          var_al;
	logic [SD_W-1:0]          root;
	logic signed [WIDE_W-1:0] mean_ext;

	assign dm_abs  = delta_q[MAG_W-1] ? MAG_W'(-delta_q) : MAG_W'(delta_q);
	// left-align the mean delta so the quotient lands in the low bits
	assign div_dvd = cmd.div_mag ? {dm_abs, {(DVD_W - MAG_W){1'b0}}} : m2_q;
	assign div_dsr = cmd.div_mag ? count_q : count_q - 32'd1;

	rmsd_div u_div (
		.clk       (clk),
		.load      (cmd.div_mag | cmd.div_var),
		.step      (cmd.div_step),
		.dividend  (div_dvd),
		.divisor   (div_dsr),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// round to nearest, ties away from zero: bump when 2r >= n
	assign rnd_up = {div_rem, 1'b0} >= {1'b0, count_q};
	assign q_next = div_quo[MAG_W-1:0] + MAG_W'(rnd_up);

	assign mul_sum = {1'b0, prod_q[PW-1:MAG_W]} + (prod_q[0] ? {1'b0, dm_q} : '0);

	assign rounded = {1'b0, prod_q} + HALF;
	assign scaled  = EW'(rounded) >> MEAN_FRAC_BITS;
	assign ovf     = |scaled[EW-1:M2_W];
	assign acc_sum = {1'b0, m2_q} + {1'b0, add_q};

	// move the variance to 16 fraction bits
	if (MEAN_FRAC_BITS < SD_ALIGN_FRAC) begin : g_up
		localparam int SH = SD_ALIGN_FRAC - MEAN_FRAC_BITS;
		assign var_al = (|div_quo[M2_W-1 -: SH]) ? '1 : (div_quo << SH);
	end else if (MEAN_FRAC_BITS > SD_ALIGN_FRAC) begin : g_dn
		assign var_al = div_quo >> (MEAN_FRAC_BITS - SD_ALIGN_FRAC);
	end else begin : g_eq
		assign var_al = div_quo;
	end

	rmsd_sqrt u_sqrt (
		.clk   (clk),
		.load  (cmd.sqrt_load),
		.step  (cmd.sqrt_step),
		.value (var_al),
		.root  (root)
	);

	assign mean_ext = WIDE_W'(mean_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			mean_q      <= '0;
			m2_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load && !st.full) begin
				count_q <= count_q + 32'd1;
			end
			if (cmd.mean_upd) begin
				mean_q <= neg_q ? mean_q - $signed(q_q[QW-1:0])
					: mean_q + $signed(q_q[QW-1:0]);
			end
			if (cmd.m2_acc) begin
				m2_q <= acc_sum[M2_W] ? '1 : acc_sum[M2_W-1:0];
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			xq_q  <= {sample_mm, {MEAN_FRAC_BITS{1'b0}}};
			sat_q <= st.full;
		end
		if (cmd.delta) begin
			delta_q <= $signed({xq_q[QW-1], xq_q}) - $signed({mean_q[QW-1], mean_q});
		end
		if (cmd.div_mag) begin
			dm_q  <= dm_abs;
			neg_q <= delta_q[MAG_W-1];
		end
		if (cmd.round) begin
			q_q <= q_next;
		end
		if (cmd.mean_upd) begin
			prod_q <= {{MAG_W{1'b0}}, dm_q - q_q};
		end else if (cmd.mul_step) begin
			prod_q <= {mul_sum, prod_q[MAG_W-1:1]};
		end
		if (cmd.m2_round) begin
			add_q <= ovf ? '1 : scaled[M2_W-1:0];
			if (ovf) begin
				sat_q <= 1'b1;
			end
		end
		if (cmd.m2_acc && acc_sum[M2_W]) begin
			sat_q <= 1'b1;
		end
		if (cmd.sd_zero) begin
			sd_q <= '0;
		end else if (cmd.sd_take) begin
			sd_q <= root;
		end
		if (cmd.out_load) begin
			cnt_out_q  <= count_q;
			mean_out_q <= mean_ext[MEAN_OUT_W-1:0];
			sd_out_q   <= sd_q;
			sat_out_q  <= sat_q;
		end
	end

	assign st.full     = &count_q;
	assign st.few      = ~|count_q[COUNT_W-1:1];
	assign st.out_free = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign sample_count = cnt_out_q;
	assign mean_q16     = mean_out_q;
	assign stddev_q8    = sd_out_q;
	assign saturated    = sat_out_q;

	`RMSD_CHECK(a_count_step, (count_q == $past(count_q)) || ($past(cmd.load) && count_q == $past(count_q) + 32'd1), "count moved without a request or by more than one")
	`RMSD_CHECK(a_mean_hold, (mean_q == $past(mean_q)) || $past(cmd.mean_upd), "mean changed outside its update")
	`RMSD_CHECK(a_m2_grows, m2_q >= $past(m2_q), "sum of squared deviations decreased")
	`RMSD_NEXT(a_full_sat, cmd.load && st.full, sat_q, "request at full count not flagged")

endmodule

FILE: sv/rmsd_ctrl.sv
// Controller: sequences the datapath through one Welford update per request, none at full count.
`include "running_mean_stddev_unit_assert.svh"
module rmsd_ctrl #(
	parameter int MAG_W = 41
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  rmsd_pkg::stat_t  st,
	output rmsd_pkg::cmd_t   cmd
);
	import rmsd_pkg::*;

	typedef enum logic [14:0] {
		S_IDLE = 15'h0001,
		S_DLT  = 15'h0002,
		S_DVL  = 15'h0004,
		S_DVM  = 15'h0008,
		S_RND  = 15'h0010,
		S_MUP  = 15'h0020,
		S_MUL  = 15'h0040,
		S_RSH  = 15'h0080,
		S_ACC  = 15'h0100,
		S_VLD  = 15'h0200,
		S_DVV  = 15'h0400,
		S_ALN  = 15'h0800,
		S_SQ   = 15'h1000,
		S_SDT  = 15'h2000,
		S_DONE = 15'h4000
	} state_t;

	state_t            state_q;
	state_t            state_d;
	logic [ITER_W-1:0] cnt_q;
	logic [ITER_W-1:0] cnt_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		cnt_d   = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					// full count: keep the state, report the current statistics
					state_d  = st.full ? S_DONE : S_DLT;
				end
			end
			S_DLT: begin
				cmd.delta = 1'b1;
				state_d   = S_DVL;
			end
			S_DVL: begin
				cmd.div_mag = 1'b1;
				cnt_d       = ITER_W'(MAG_W - 1);
				state_d     = S_DVM;
			end
			S_DVM: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = S_RND;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			S_RND: begin
				cmd.round = 1'b1;
				state_d   = S_MUP;
			end
			S_MUP: begin
				cmd.mean_upd = 1'b1;
				cnt_d        = ITER_W'(MAG_W - 1);
				state_d      = S_MUL;
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = S_RSH;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			S_RSH: begin
				cmd.m2_round = 1'b1;
				state_d      = S_ACC;
			end
			S_ACC: begin
				cmd.m2_acc = 1'b1;
				if (st.few) begin
					cmd.sd_zero = 1'b1;
					state_d     = S_DONE;
				end else begin
					state_d = S_VLD;
				end
			end
			S_VLD: begin
				cmd.div_var = 1'b1;
				cnt_d       = ITER_W'(DIV_STEPS - 1);
				state_d     = S_DVV;
			end
			S_DVV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = S_ALN;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			S_ALN: begin
				cmd.sqrt_load = 1'b1;
				cnt_d         = ITER_W'(SQRT_STEPS - 1);
				state_d       = S_SQ;
			end
			S_SQ: begin
				cmd.sqrt_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = S_SDT;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			S_SDT: begin
				cmd.sd_take = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				// hold until the output register can take the result
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	`RMSD_NEXT(a_busy_after_req, (state_q == S_IDLE) && in_valid, in_stall, "took a request but did not go busy")
	`RMSD_NEXT(a_full_skips, cmd.load && st.full, state_q == S_DONE, "request at full count was processed")
	`RMSD_NEXT(a_var_div_len, (state_q == S_DVV) && (cnt_q == '0), state_q == S_ALN, "variance divide did not end on its last step")

endmodule

FILE: sv/running_mean_stddev_unit.sv
// Welford running mean and sample standard deviation unit, top level.
// Each request runs two bit-serial passes (mean divide, multiply), a 64-step variance divide
//   and a 32-step square root; in_stall stays high until its result enters the output register.
// A request at full count skips the update; with fewer than two samples the divide and root are skipped.
// Reset (arst_n low) clears count, mean, sum of squares and the controller at once.
module running_mean_stddev_unit #(
	parameter int SAMPLE_BITS    = 24,
	parameter int MEAN_FRAC_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [SAMPLE_BITS-1:0]          sample_mm,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [rmsd_pkg::COUNT_W-1:0]           sample_count,
	output logic signed [rmsd_pkg::MEAN_OUT_W-1:0] mean_q16,
	output logic [rmsd_pkg::SD_W-1:0]              stddev_q8,
	output logic                                   saturated
);
	import rmsd_pkg::*;

	cmd_t  cmd;
	stat_t st;

	rmsd_ctrl #(
		.MAG_W (SAMPLE_BITS + MEAN_FRAC_BITS + 1)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	rmsd_dp #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.MEAN_FRAC_BITS (MEAN_FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.sample_mm    (sample_mm),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample_count (sample_count),
		.mean_q16     (mean_q16),
		.stddev_q8    (stddev_q8),
		.saturated    (saturated)
	);

endmodule

FILE: tb/running_mean_stddev_unit_tb.sv
// Self-checking testbench for the running mean and standard deviation unit.
`timescale 1ns / 1ps

module running_mean_stddev_unit_tb;

	localparam int SAMPLE_W   = 24;
	localparam int FRAC_W     = 16;
	localparam int LONG_HOLD  = 1500;
	localparam int HOLD_AT_A  = 250;
	localparam int HOLD_AT_B  = 1400;
	localparam int TAIL_WAIT  = 400;

	typedef struct packed {
		logic [rmsd_pkg::COUNT_W-1:0]    count;
		logic [rmsd_pkg::MEAN_OUT_W-1:0] mean;
		logic [rmsd_pkg::SD_W-1:0]       sd;
		logic                            sat;
	} stats_t;

	logic                                   clk = 1'b0;
	logic                                   arst_n = 1'b0;
	logic                                   in_valid = 1'b0;
	logic                                   in_stall;
	logic signed [SAMPLE_W-1:0]             sample_mm = '0;
	logic                                   out_valid;
	logic                                   out_stall = 1'b0;
	logic [rmsd_pkg::COUNT_W-1:0]           sample_count;
	logic signed [rmsd_pkg::MEAN_OUT_W-1:0] mean_q16;
	logic [rmsd_pkg::SD_W-1:0]              stddev_q8;
	logic                                   saturated;

	// Shadow statistics of the unit
	logic [rmsd_pkg::COUNT_W-1:0] n_seen = '0;
	logic signed [63:0]           mean_acc = '0;
	logic [63:0]                  m2_acc = '0;

	logic signed [SAMPLE_W-1:0] pending_samples[$];
	stats_t                     expected_stats[$];
	int                         send_idle_pct = 0;
	int                         recv_idle_pct = 0;
	int                         results_seen = 0;
	int                         hold_left = 0;
	int                         errors = 0;

	running_mean_stddev_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_mm    (sample_mm),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample_count (sample_count),
		.mean_q16     (mean_q16),
		.stddev_q8    (stddev_q8),
		.saturated    (saturated)
	);

	always #2 clk = ~clk;

	function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
		logic [31:0] root;
		logic [31:0] trial;
		root = '0;
		for (int i = 31; i >= 0; i--) begin
			trial = root | (32'd1 << i);
			if ({32'd0, trial} * {32'd0, trial} <= v)
				root = trial;
		end
		return root;
	endfunction

	// Welford update of the shadow state; returns the statistics for this request
	function automatic stats_t welford_update(input logic signed [SAMPLE_W-1:0] x);
		logic signed [63:0] xq;
		logic signed [63:0] delta;
		logic signed [63:0] delta2;
		logic [63:0]        dm;
		logic [63:0]        dm2;
		logic [63:0]        n;
		logic [63:0]        rem;
		logic [63:0]        q;
		logic [63:0]        lo;
		logic [63:0]        var_q;
		logic [127:0]       prod;
		logic [64:0]        sum;
		stats_t             r;
		r.sat = 1'b0;
		if (n_seen == '1) begin
			r.sat = 1'b1;
		end else begin
			n_seen = n_seen + 1'b1;
			n = {32'd0, n_seen};
			xq = {{(64-SAMPLE_W){x[SAMPLE_W-1]}}, x};
			xq = xq <<< FRAC_W;
			delta = xq - mean_acc;
			dm = delta[63] ? 64'(-delta) : 64'(delta);
			// round to nearest, ties away from zero
			rem = dm % n;
			q = dm / n + ((rem >= n - rem) ? 64'd1 : 64'd0);
			mean_acc = delta[63] ? mean_acc - $signed(q) : mean_acc + $signed(q);
			delta2 = xq - mean_acc;
			dm2 = delta2[63] ? 64'(-delta2) : 64'(delta2);
			prod = {64'd0, dm} * {64'd0, dm2};
			prod = prod + (128'd1 << (FRAC_W - 1));
			lo = prod[FRAC_W +: 64];
			if (prod[127:FRAC_W+64] != '0) begin
				lo = '1;
				r.sat = 1'b1;
			end
			sum = {1'b0, m2_acc} + {1'b0, lo};
			if (sum[64]) begin
				m2_acc = '1;
				r.sat = 1'b1;
			end else begin
				m2_acc = sum[63:0];
			end
		end
		r.count = n_seen;
		r.mean = mean_acc[rmsd_pkg::MEAN_OUT_W-1:0];
		if (n_seen < 2) begin
			r.sd = '0;
		end else begin
			var_q = m2_acc / {32'd0, n_seen - 1'b1};
			r.sd = floor_sqrt(var_q);
		end
		return r;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] rand_sample(input int center);
		int pick;
		int v;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			v = center + int'($urandom_range(0, 4000)) - 2000;
		else if (pick < 85)
			v = int'($urandom_range(0, 131071)) - 65536;
		else if (pick < 97)
			v = int'($urandom_range(0, 15)) - 8;
		else
			v = int'($urandom_range(0, 2097151)) - 1048576;
		return v[SAMPLE_W-1:0];
	endfunction

	// Request side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			sample_mm <= '0;
		end else begin
			if (in_valid && !in_stall)
				expected_stats.push_back(welford_update(sample_mm));
			// hold the request while stalled
			if (!in_valid || !in_stall) begin
				if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					sample_mm <= pending_samples.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result side
	always @(posedge clk or negedge arst_n) begin : result_check
		stats_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_stats.size() == 0) begin
					$error("result with no request pending: count %0d", sample_count);
					errors++;
				end else begin
					want = expected_stats.pop_front();
					if (sample_count !== want.count) begin
						$error("sample_count: expected %0d, got %0d", want.count, sample_count);
						errors++;
					end
					if (mean_q16 !== $signed(want.mean)) begin
						$error("mean_q16: expected %0d, got %0d", $signed(want.mean), mean_q16);
						errors++;
					end
					if (stddev_q8 !== want.sd) begin
						$error("stddev_q8: expected %0d, got %0d", want.sd, stddev_q8);
						errors++;
					end
					if (saturated !== want.sat) begin
						$error("saturated: expected %0d, got %0d", want.sat, saturated);
						errors++;
					end
				end
				results_seen++;
				// back up the unit so that its input stalls
				if (results_seen == HOLD_AT_A || results_seen == HOLD_AT_B)
					hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	task automatic drain_requests();
		while (pending_samples.size() != 0 || in_valid || expected_stats.size() != 0)
			@(negedge clk);
	endtask

	initial begin : stimulus
		int center;
		logic signed [SAMPLE_W-1:0] opening[$];
		center = 0;
		opening = '{24'sd0, 24'sd1, -24'sd1, 24'sd5, 24'sd5, 24'sd100, -24'sd100,
			24'sd8388607, -24'sd8388608, 24'sd0, 24'sd12345, -24'sd12345, 24'sd7,
			24'sd7, 24'sd7, 24'sd3, -24'sd3, 24'sd65535, -24'sd65536, 24'sd2, 24'sd1};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 7;
		recv_idle_pct = 48;
		foreach (opening[i])
			pending_samples.push_back(opening[i]);
		for (int i = 0; i < 620; i++) begin
			center = center + int'($urandom_range(0, 2000)) - 1000;
			if (center > 60000 || center < -60000)
				center = 0;
			pending_samples.push_back(rand_sample(center));
		end
		drain_requests();

		send_idle_pct = 48;
		recv_idle_pct = 7;
		for (int i = 0; i < 620; i++) begin
			center = center + int'($urandom_range(0, 2000)) - 1000;
			if (center > 60000 || center < -60000)
				center = 0;
			pending_samples.push_back(rand_sample(center));
		end
		drain_requests();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < 620; i++) begin
			center = center + int'($urandom_range(0, 2000)) - 1000;
			if (center > 60000 || center < -60000)
				center = 0;
			pending_samples.push_back(rand_sample(center));
		end
		// drive the sum of squares into saturation, then keep sampling
		for (int i = 0; i < 4; i++) begin
			pending_samples.push_back(24'sd8388607);
			pending_samples.push_back(-24'sd8388608);
		end
		pending_samples.push_back(24'sd0);
		pending_samples.push_back(rand_sample(center));
		drain_requests();

		repeat (TAIL_WAIT) @(posedge clk);
		if (errors == 0 && expected_stats.size() == 0)
			$display("running_mean_stddev_unit test passed");
		else
			$display("running_mean_stddev_unit test failed");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("running_mean_stddev_unit test failed");
		$finish;
	end

endmodule
